>>> rtl/core/unordered_number_set_table_defines.svh
// Assertion macros for the unordered number set table.
`ifndef UNORDERED_NUMBER_SET_TABLE_DEFINES_SVH
`define UNORDERED_NUMBER_SET_TABLE_DEFINES_SVH

// Check a condition at every clock edge outside reset.
`define UNST_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("unst assertion failed");

// Check a condition in the cycle after a trigger.
`define UNST_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("unst assertion failed");

`endif

>>> rtl/core/unst_pkg.sv
package unst_pkg;

    localparam int CAPACITY  = 64;
    localparam int NUM_W     = 32;

    localparam int CMD_W     = 2;
    localparam int NUMBER_W  = 32;
    localparam int INDEX_W   = 6;
    localparam int STATUS_W  = 2;
    localparam int VALUE_W   = 32;
    localparam int COUNT_W   = 7;

    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int SLOT_W    = ($clog2(CAPACITY) > INDEX_W) ? $clog2(CAPACITY) : INDEX_W;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD      = 2'd0,
        CMD_REMOVE   = 2'd1,
        CMD_CONTAINS = 2'd2,
        CMD_GET      = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_MISS  = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    typedef struct packed {
        logic              commit_add;
        logic              commit_remove;
        logic [NUM_W-1:0]  number;
        logic [SLOT_W-1:0] index;
        logic [NUM_W-1:0]  last_data;
    } cell_ctrl_t;

    typedef struct packed {
        logic             valid;
        logic             match;
        logic             rd_hit;
        logic [NUM_W-1:0] rd_data;
        logic [NUM_W-1:0] last_data;
    } cell_stat_t;

endpackage

>>> rtl/core/unst_ifs.sv
interface unst_in_if import unst_pkg::*;;
    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    cmd;
    logic [NUMBER_W-1:0] number;
    logic [INDEX_W-1:0]  index;

    modport source (output valid, output cmd, output number, output index, input ready);
    modport sink (input valid, input cmd, input number, input index, output ready);
endinterface

interface unst_out_if import unst_pkg::*;;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic                found;
    logic [VALUE_W-1:0]  value;
    logic [COUNT_W-1:0]  count;

    modport source (output valid, output status, output found, output value, output count,
                    input ready);
    modport sink (input valid, input status, input found, input value, input count,
                  output ready);
endinterface

>>> rtl/core/unst_cell.sv
module unst_cell import unst_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cell_ctrl_t        ctrl,
    input  logic [SLOT_W-1:0] slot,
    input  logic              prev_valid,
    input  logic              next_valid,
    output cell_stat_t        stat
);

    logic             valid_reg;
    logic             valid_next;
    logic [NUM_W-1:0] entry_reg;
    logic [NUM_W-1:0] entry_next;
    logic             is_last;
    logic             is_free;
    logic             match;
    logic             sel;

    assign match   = valid_reg && (entry_reg == ctrl.number);
    assign is_last = valid_reg && !next_valid;
    assign is_free = !valid_reg && prev_valid;
    assign sel     = valid_reg && (ctrl.index == slot);

    always_comb
    begin
        valid_next = valid_reg;
        entry_next = entry_reg;
        if (ctrl.commit_add && is_free)
        begin
            valid_next = 1'b1;
            entry_next = ctrl.number;
        end
        if (ctrl.commit_remove)
        begin
            if (match)
            begin
                entry_next = ctrl.last_data;
            end
            if (is_last)
            begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign stat.valid     = valid_reg;
    assign stat.match     = match;
    assign stat.rd_hit    = sel;
    assign stat.rd_data   = sel ? entry_reg : '0;
    assign stat.last_data = is_last ? entry_reg : '0;

endmodule

>>> rtl/core/unordered_number_set_table.sv
// Unordered number set table.
// request channel: one item per command (cmd, number, index); cmd selects add,
// remove, contains or get item. response channel: one item per command with
// status, found, value and count after the command.
// For each item the command is registered first; then every
// cell of the row compares its entry with the number in parallel, the row
// drives the entry at the index and the last entry, and the cells update.
// The result is registered into the output register when the item commits;
// a new request is taken only after the previous item has committed.
// The response is held in an output register; when the receiver stalls, one
// further request is accepted and waits in the execute step until the
// output register frees up.
// Remove moves the last entry into the gap, so get item sees the swapped
// order. Add of a new number to a full set gives status full.
// Reset empties the set at once (all cell valid bits cleared); the entry
// words themselves are not cleared and need no sweep.
`include "unordered_number_set_table_defines.svh"

module unordered_number_set_table import unst_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    unst_in_if.sink    request,
    unst_out_if.source response
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    cmd_t                cmd_reg;
    logic [NUM_W-1:0]    number_reg;
    logic [INDEX_W-1:0]  index_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;

    logic                out_valid_reg;
    logic [STATUS_W-1:0] status_reg;
    logic                found_reg;
    logic [VALUE_W-1:0]  value_reg;
    logic [COUNT_W-1:0]  count_out_reg;

    cell_ctrl_t          ctrl;
    cell_stat_t          stat [CAPACITY];
    logic [CAPACITY-1:0] valid_vec;
    logic [CAPACITY-1:0] match_vec;
    logic                hit;
    logic                rd_hit;
    logic [NUM_W-1:0]    rd_data;
    logic [NUM_W-1:0]    last_data;
    logic                full;
    logic                accept;
    logic                commit;
    status_t             status_c;
    logic [VALUE_W-1:0]  value_c;

    assign accept        = request.valid && request.ready;
    assign request.ready = (state_reg == S_IDLE);
    assign commit        = (state_reg == S_EXEC) && (!out_valid_reg || response.ready);
    assign full          = (count_reg == CNT_W'(CAPACITY));

    always_comb
    begin
        hit       = 1'b0;
        rd_hit    = 1'b0;
        rd_data   = '0;
        last_data = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            valid_vec[i] = stat[i].valid;
            match_vec[i] = stat[i].match;
            hit          = hit | stat[i].match;
            rd_hit       = rd_hit | stat[i].rd_hit;
            rd_data      = rd_data | stat[i].rd_data;
            last_data    = last_data | stat[i].last_data;
        end
    end

    assign ctrl.commit_add    = commit && (cmd_reg == CMD_ADD) && !hit && !full;
    assign ctrl.commit_remove = commit && (cmd_reg == CMD_REMOVE) && hit;
    assign ctrl.number        = number_reg;
    assign ctrl.index         = SLOT_W'(index_reg);
    assign ctrl.last_data     = last_data;

    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic prev_v;
        logic next_v;
        if (g == 0)
        begin : g_first
            assign prev_v = 1'b1;
        end
        else
        begin : g_prev
            assign prev_v = stat[g-1].valid;
        end
        if (g == CAPACITY - 1)
        begin : g_end
            assign next_v = 1'b0;
        end
        else
        begin : g_next
            assign next_v = stat[g+1].valid;
        end
        unst_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .slot       (SLOT_W'(g)),
            .prev_valid (prev_v),
            .next_valid (next_v),
            .stat       (stat[g])
        );
    end

    always_comb
    begin
        status_c   = ST_OK;
        value_c    = '0;
        count_next = count_reg;
        case (cmd_reg)
            CMD_ADD:
            begin
                if (hit)
                begin
                    status_c = ST_MISS;
                end
                else if (full)
                begin
                    status_c = ST_FULL;
                end
                else
                begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            CMD_REMOVE:
            begin
                if (hit)
                begin
                    count_next = count_reg - CNT_W'(1);
                end
                else
                begin
                    status_c = ST_MISS;
                end
            end
            CMD_CONTAINS:
            begin
                status_c = hit ? ST_OK : ST_MISS;
            end
            CMD_GET:
            begin
                if (rd_hit)
                begin
                    value_c = VALUE_W'(rd_data);
                end
                else
                begin
                    status_c = ST_RANGE;
                end
            end
            default:
            begin
                status_c = ST_OK;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (commit)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (commit)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (response.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg    <= cmd_t'(request.cmd);
            number_reg <= NUM_W'(request.number);
            index_reg  <= request.index;
        end
        if (commit)
        begin
            status_reg    <= status_c;
            found_reg     <= hit;
            value_reg     <= value_c;
            count_out_reg <= COUNT_W'(count_next);
        end
    end

    assign response.valid  = out_valid_reg;
    assign response.status = status_reg;
    assign response.found  = found_reg;
    assign response.value  = value_reg;
    assign response.count  = count_out_reg;

    `UNST_ASSERT_ALWAYS(a_count_matches_valid, ($countones(valid_vec) == int'(count_reg)))
    `UNST_ASSERT_ALWAYS(a_single_match, $onehot0(match_vec))
    `UNST_ASSERT_NEXT(a_add_grows, ctrl.commit_add,
        (count_reg == $past(count_reg) + CNT_W'(1)))
    `UNST_ASSERT_NEXT(a_remove_shrinks, ctrl.commit_remove,
        (count_reg == $past(count_reg) - CNT_W'(1)))

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import unst_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int POOL_SIZE   = 96;
    localparam int LONG_HOLD   = 400;

    typedef struct {
        cmd_t                cmd;
        logic [NUMBER_W-1:0] number;
        logic [INDEX_W-1:0]  index;
    } set_command_t;

    typedef struct {
        status_t            status;
        logic               found;
        logic [VALUE_W-1:0] value;
        logic [COUNT_W-1:0] count;
    } set_reply_t;

    logic clk = 1'b0;
    logic rst_n;

    unst_in_if  request_if ();
    unst_out_if response_if ();

    unordered_number_set_table i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (request_if),
        .response (response_if)
    );

    set_command_t        pending_commands[$];
    set_reply_t          awaited_replies[$];
    logic [NUM_W-1:0]    shadow_entries[CAPACITY];
    int                  shadow_size;
    logic [NUMBER_W-1:0] number_pool[POOL_SIZE];

    int sender_idle_pct;
    int receiver_idle_pct;
    bit hold_request;
    bit hold_ack;
    int hold_left;
    bit offer_taken;

    int error_count;
    int commands_accepted;
    int replies_checked;
    int peak_size;
    int full_refusals;
    int cycle_count;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic set_reply_t apply_to_shadow_set(cmd_t cmd, logic [NUMBER_W-1:0] number,
                                                       logic [INDEX_W-1:0] index);
        logic [NUM_W-1:0] key;
        int               slot;
        set_reply_t       reply;
        key = NUM_W'(number);
        slot = -1;
        for (int i = 0; i < shadow_size; i++)
        begin
            if (slot < 0 && shadow_entries[i] == key)
                slot = i;
        end
        reply.status = ST_OK;
        reply.found  = (slot >= 0);
        reply.value  = '0;
        case (cmd)
            CMD_ADD:
            begin
                if (slot >= 0)
                    reply.status = ST_MISS;
                else if (shadow_size >= CAPACITY)
                begin
                    reply.status = ST_FULL;
                    full_refusals++;
                end
                else
                begin
                    shadow_entries[shadow_size] = key;
                    shadow_size++;
                    if (shadow_size > peak_size)
                        peak_size = shadow_size;
                end
            end
            CMD_REMOVE:
            begin
                if (slot >= 0)
                begin
                    shadow_size--;
                    shadow_entries[slot] = shadow_entries[shadow_size];
                end
                else
                    reply.status = ST_MISS;
            end
            CMD_CONTAINS:
            begin
                reply.status = (slot >= 0) ? ST_OK : ST_MISS;
            end
            default:
            begin
                if (int'(index) < shadow_size)
                    reply.value = VALUE_W'(shadow_entries[index]);
                else
                    reply.status = ST_RANGE;
            end
        endcase
        reply.count = COUNT_W'(shadow_size);
        return reply;
    endfunction

    function automatic void check_field(string field, logic [63:0] want, logic [63:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", field, want, got);
            error_count++;
        end
    endfunction

    // Request side: drive at the falling edge, record acceptance at the rising edge.
    always @(negedge clk)
    begin
        if (!rst_n)
            request_if.valid <= 1'b0;
        else if (!request_if.valid || offer_taken)
        begin
            if (pending_commands.size() > 0 && $urandom_range(99) >= sender_idle_pct)
            begin
                request_if.valid  <= 1'b1;
                request_if.cmd    <= pending_commands[0].cmd;
                request_if.number <= pending_commands[0].number;
                request_if.index  <= pending_commands[0].index;
            end
            else
                request_if.valid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && request_if.valid && request_if.ready)
        begin
            awaited_replies.push_back(apply_to_shadow_set(cmd_t'(request_if.cmd),
                                                          request_if.number, request_if.index));
            void'(pending_commands.pop_front());
            commands_accepted++;
        end
        offer_taken <= rst_n && request_if.valid && request_if.ready;
    end

    // Response side.
    always @(negedge clk)
    begin
        if (hold_request != hold_ack)
        begin
            hold_ack          <= hold_request;
            hold_left         <= LONG_HOLD;
            response_if.ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left         <= hold_left - 1;
            response_if.ready <= 1'b0;
        end
        else
            response_if.ready <= ($urandom_range(99) >= receiver_idle_pct);
    end

    always @(posedge clk)
    begin
        set_reply_t want;
        if (rst_n && response_if.valid && response_if.ready)
        begin
            if (awaited_replies.size() == 0)
            begin
                $error("response item with no command outstanding");
                error_count++;
            end
            else
            begin
                want = awaited_replies.pop_front();
                check_field("status", 64'(want.status), 64'(response_if.status));
                check_field("found", 64'(want.found), 64'(response_if.found));
                check_field("value", 64'(want.value), 64'(response_if.value));
                check_field("count", 64'(want.count), 64'(response_if.count));
                replies_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout: %0d commands still queued, %0d replies awaited",
                     pending_commands.size(), awaited_replies.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic queue_command(cmd_t cmd, logic [NUMBER_W-1:0] number,
                                 logic [INDEX_W-1:0] index);
        set_command_t item;
        item.cmd    = cmd;
        item.number = number;
        item.index  = index;
        pending_commands.push_back(item);
    endtask

    task automatic queue_random(int n, int add_pct, int remove_pct);
        int                  pick;
        cmd_t                cmd;
        logic [NUMBER_W-1:0] number;
        logic [INDEX_W-1:0]  index;
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(99);
            if (pick < add_pct)
                cmd = CMD_ADD;
            else if (pick < add_pct + remove_pct)
                cmd = CMD_REMOVE;
            else if (pick[0])
                cmd = CMD_CONTAINS;
            else
                cmd = CMD_GET;
            if ($urandom_range(99) < 85)
                number = number_pool[$urandom_range(POOL_SIZE - 1)];
            else
                number = $urandom;
            index = $urandom_range(1) ? INDEX_W'($urandom_range(63)) : INDEX_W'($urandom_range(15));
            queue_command(cmd, number, index);
        end
    endtask

    task automatic drain;
        while (pending_commands.size() > 0 || awaited_replies.size() > 0)
            @(posedge clk);
    endtask

    initial
    begin
        rst_n              = 1'b0;
        request_if.valid   = 1'b0;
        request_if.cmd     = CMD_ADD;
        request_if.number  = '0;
        request_if.index   = '0;
        response_if.ready  = 1'b0;
        sender_idle_pct    = 21;
        receiver_idle_pct  = 57;
        hold_request       = 1'b0;
        hold_ack           = 1'b0;
        hold_left          = 0;
        offer_taken        = 1'b0;
        error_count        = 0;
        commands_accepted  = 0;
        replies_checked    = 0;
        peak_size          = 0;
        full_refusals      = 0;
        cycle_count        = 0;
        shadow_size        = 0;
        for (int i = 0; i < POOL_SIZE; i++)
            number_pool[i] = $urandom;
        number_pool[0] = '0;
        number_pool[1] = '1;
        number_pool[2] = 32'h8000_0000;
        number_pool[3] = 32'h0000_0001;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        queue_command(CMD_GET, '0, 6'd0);
        queue_command(CMD_CONTAINS, '0, '0);
        queue_command(CMD_REMOVE, 32'd5, '0);
        queue_command(CMD_ADD, '0, '0);
        queue_command(CMD_ADD, '1, '1);
        queue_command(CMD_ADD, 32'h8000_0000, '0);
        queue_command(CMD_ADD, '0, '0);
        queue_command(CMD_CONTAINS, '1, '0);
        queue_command(CMD_CONTAINS, 32'h0000_0001, '0);
        queue_command(CMD_GET, '0, 6'd0);
        queue_command(CMD_GET, '0, 6'd2);
        queue_command(CMD_GET, '0, 6'd3);
        queue_command(CMD_GET, '0, 6'd63);
        queue_command(CMD_GET, '1, 6'd1);
        queue_command(CMD_REMOVE, '0, '0);
        queue_command(CMD_GET, '0, 6'd0);
        queue_command(CMD_REMOVE, '1, '0);
        queue_command(CMD_GET, '0, 6'd1);
        queue_command(CMD_REMOVE, '1, '0);
        queue_command(CMD_REMOVE, 32'h8000_0000, '0);
        queue_command(CMD_ADD, 32'h5555_5555, '0);
        queue_command(CMD_ADD, 32'hAAAA_AAAA, '0);
        queue_command(CMD_GET, 32'hAAAA_AAAA, 6'h2A);
        queue_command(CMD_GET, '0, 6'd1);
        drain();

        queue_random(60, 35, 25);
        hold_request = ~hold_request;
        queue_random(40, 40, 20);
        drain();
        queue_random(100, 85, 5);
        queue_random(20, 30, 30);
        drain();

        sender_idle_pct   = 57;
        receiver_idle_pct = 21;
        queue_random(80, 10, 70);
        queue_random(120, 35, 30);
        drain();

        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        queue_random(120, 70, 10);
        queue_random(90, 30, 35);
        drain();

        repeat (10) @(posedge clk);
        $display("Ran %0d add/remove/contains/get commands, checked %0d responses.",
                 commands_accepted, replies_checked);
        $display("Set grew to %0d entries, %0d adds refused as full.", peak_size, full_refusals);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
